[rtl/core/opd_pkg.sv]
// Shared types, register codes and the sequencer program for the OOK pulse-pair decoder.
// No dependencies; every other file of the core imports this package.
package opd_pkg;

  localparam int PULSE_SLOTS_DEF = 256;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [19:0] MAX_GAP_RST     = 20'd20000;
  localparam logic [19:0] SYNC_GAP_RST    = 20'd8000;
  localparam logic [8:0]  MIN_PULSES_RST  = 9'd40;
  localparam logic [15:0] SHORT_LIMIT_RST = 16'd600;
  localparam logic [7:0]  MIN_BITS_RST    = 8'd32;
  localparam logic [7:0]  BITS_MAX        = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_GAP     = 3'd0,
    REG_SYNC_GAP    = 3'd1,
    REG_MIN_PULSES  = 3'd2,
    REG_SHORT_LIMIT = 3'd3,
    REG_MIN_BITS    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic        line_level;
    logic [31:0] time_us;
  } in_word_t;

  typedef struct packed {
    logic [25:0] address;
    logic [3:0]  unit;
    logic        switch_on;
    logic [7:0]  bit_count;
  } out_word_t;

  // Datapath actions, one per control word
  typedef enum logic [3:0] {
    A_NOP,
    A_WAIT,
    A_GAP,
    A_STORE,
    A_INIT,
    A_RD1,
    A_RD2,
    A_PAIR,
    A_EMIT,
    A_CLEAR
  } act_t;

  // Jump conditions; a true condition loads the target, else the step advances
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_EDGE,
    C_OVER_MAX,
    C_NOT_SYNC,
    C_FEW_MARKS,
    C_LOOP_DONE,
    C_FEW_BITS,
    C_OUT_BUSY
  } cond_t;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t ST_WAIT   = 4'd0;
  localparam pc_t ST_GAP    = 4'd1;
  localparam pc_t ST_STORE  = 4'd2;
  localparam pc_t ST_CHECK  = 4'd3;
  localparam pc_t ST_RD1    = 4'd4;
  localparam pc_t ST_RD2    = 4'd5;
  localparam pc_t ST_PAIR   = 4'd6;
  localparam pc_t ST_FINISH = 4'd7;
  localparam pc_t ST_EMIT   = 4'd8;
  localparam pc_t ST_CLEAR  = 4'd9;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    pc_t   target;
  } ctrl_word_t;

  typedef struct packed {
    logic no_edge;
    logic over_max;
    logic not_sync;
    logic few_marks;
    logic loop_done;
    logic few_bits;
    logic out_busy;
  } status_t;

  // Microprogram
  function automatic ctrl_word_t useq_rom(input pc_t pc);
    ctrl_word_t w;
    w = '{act: A_NOP, cond: C_ALWAYS, target: ST_WAIT};
    unique case (pc)
      ST_WAIT:   w = '{act: A_WAIT,  cond: C_NO_EDGE,   target: ST_WAIT};
      ST_GAP:    w = '{act: A_GAP,   cond: C_OVER_MAX,  target: ST_WAIT};
      ST_STORE:  w = '{act: A_STORE, cond: C_NOT_SYNC,  target: ST_WAIT};
      ST_CHECK:  w = '{act: A_INIT,  cond: C_FEW_MARKS, target: ST_CLEAR};
      ST_RD1:    w = '{act: A_RD1,   cond: C_LOOP_DONE, target: ST_FINISH};
      ST_RD2:    w = '{act: A_RD2,   cond: C_NEVER,     target: ST_WAIT};
      ST_PAIR:   w = '{act: A_PAIR,  cond: C_ALWAYS,    target: ST_RD1};
      ST_FINISH: w = '{act: A_NOP,   cond: C_FEW_BITS,  target: ST_CLEAR};
      ST_EMIT:   w = '{act: A_EMIT,  cond: C_OUT_BUSY,  target: ST_EMIT};
      ST_CLEAR:  w = '{act: A_CLEAR, cond: C_ALWAYS,    target: ST_WAIT};
      default:   w = '{act: A_NOP,   cond: C_ALWAYS,    target: ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

[rtl/core/ook_pulse_pair_decoder_core.sv]
// Top level of the OOK pulse-pair remote code decoder.
// Depends on opd_pkg, opd_useq and opd_datapath.
//
// Each input word is one sample of the demodulated line with its microsecond timestamp. A
// sample at the same level as the last one is taken without leaving the wait step. A level
// change holds the input when it does not end a frame: measure, gap test, mark store; a
// pulse wider than max_gap_us ends after the gap test. A pulse wider than sync_gap_us ends
// the frame and starts the decode, which walks the stored marks a pair at a time through
// the single read port of the mark memory: three sequencer steps per pair. No input word is
// taken during a decode, nor while a finished code waits for the output to drain. The mark
// memory holds PULSE_SLOTS one-bit entries and needs no clearing after reset. Configuration
// writes are taken in any cycle and are meant for idle periods.
module ook_pulse_pair_decoder_core
  import opd_pkg::*;
#(
  parameter int PULSE_SLOTS = PULSE_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctrl_word_t ctrl;
  status_t    status;

  assign cfg_ready = 1'b1;

  opd_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  opd_datapath #(
    .PULSE_SLOTS (PULSE_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .status    (status),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

[rtl/core/opd_useq.sv]
// Step counter and control store of the decoder sequencer.
// Depends on opd_pkg for the program, control word and status types.
module opd_useq
  import opd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  status_t    status,
  output ctrl_word_t ctrl
);

  pc_t  pc_r;
  pc_t  pc_nxt;
  logic jump;

  assign ctrl = useq_rom(pc_r);

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_EDGE:   jump = status.no_edge;
      C_OVER_MAX:  jump = status.over_max;
      C_NOT_SYNC:  jump = status.not_sync;
      C_FEW_MARKS: jump = status.few_marks;
      C_LOOP_DONE: jump = status.loop_done;
      C_FEW_BITS:  jump = status.few_bits;
      C_OUT_BUSY:  jump = status.out_busy;
      default:     jump = 1'b1;
    endcase
    pc_nxt = jump ? ctrl.target : pc_t'(pc_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // the program never leaves its ten steps
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= ST_CLEAR) else $error("step counter left the program");

  // a frame end with too few marks goes straight to the clear step
  a_few_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == ST_CHECK && status.few_marks) |=> pc_r == ST_CLEAR)
    else $error("short frame not discarded");

  // a busy output holds the emit step
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == ST_EMIT && status.out_busy) |=> pc_r == ST_EMIT)
    else $error("emit step left while output busy");

endmodule

[rtl/core/opd_datapath.sv]
// Datapath of the decoder: configuration, edge timing, mark memory, pair decode and output.
// Depends on opd_pkg; driven by the control word from opd_useq.
module opd_datapath
  import opd_pkg::*;
#(
  parameter int PULSE_SLOTS = PULSE_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_word_t            ctrl,
  output status_t               status,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(PULSE_SLOTS + 1);
  localparam int AW = $clog2(PULSE_SLOTS);

  logic [19:0]   max_gap_r;
  logic [19:0]   sync_gap_r;
  logic [8:0]    min_pulses_r;
  logic [15:0]   short_limit_r;
  logic [7:0]    min_bits_r;

  logic [31:0]   last_edge_r;
  logic          prev_level_r;
  logic [31:0]   width_r;
  logic [CW-1:0] mark_count_r;
  logic [CW-1:0] idx_r;
  logic [31:0]   code_r;
  logic [7:0]    bits_r;
  logic          first_r;
  logic          rd_data_r;
  logic          out_valid_r;
  out_word_t     out_word_r;

  logic          marks [PULSE_SLOTS];

  logic          edge_take;
  logic          mark_short;
  logic          slot_free;
  logic          emit_fire;
  logic [CW:0]   idx_plus2;
  logic [CW-1:0] rd_sum;
  logic [AW-1:0] rd_addr;

  assign in_ready   = (ctrl.act == A_WAIT);
  assign edge_take  = in_valid && in_ready && (in_data.line_level != prev_level_r);
  assign mark_short = (width_r < {16'd0, short_limit_r});
  assign slot_free  = (mark_count_r < CW'(PULSE_SLOTS));
  assign idx_plus2  = {1'b0, idx_r} + (CW+1)'(2);
  assign emit_fire  = (ctrl.act == A_EMIT) && !status.out_busy;
  assign rd_sum     = (ctrl.act == A_RD2) ? CW'(idx_r + 1'b1) : idx_r;
  assign rd_addr    = rd_sum[AW-1:0];

  always_comb begin
    status.no_edge   = !edge_take;
    status.over_max  = (width_r > {12'd0, max_gap_r});
    status.not_sync  = (width_r <= {12'd0, sync_gap_r});
    status.few_marks = (32'(mark_count_r) <= 32'(min_pulses_r));
    status.loop_done = (idx_plus2 >= {1'b0, mark_count_r});
    status.few_bits  = (bits_r < min_bits_r);
    status.out_busy  = out_valid_r && !out_ready;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_gap_r     <= MAX_GAP_RST;
      sync_gap_r    <= SYNC_GAP_RST;
      min_pulses_r  <= MIN_PULSES_RST;
      short_limit_r <= SHORT_LIMIT_RST;
      min_bits_r    <= MIN_BITS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_MAX_GAP:     max_gap_r     <= cfg_wdata;
        REG_SYNC_GAP:    sync_gap_r    <= cfg_wdata;
        REG_MIN_PULSES:  min_pulses_r  <= cfg_wdata[8:0];
        REG_SHORT_LIMIT: short_limit_r <= cfg_wdata[15:0];
        REG_MIN_BITS:    min_bits_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // mark memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.act == A_STORE && slot_free) begin
      marks[mark_count_r[AW-1:0]] <= mark_short;
    end
    rd_data_r <= marks[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r  <= '0;
      prev_level_r <= 1'b0;
      mark_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (edge_take) begin
        last_edge_r  <= in_data.time_us;
        prev_level_r <= in_data.line_level;
      end
      priority if (ctrl.act == A_CLEAR || (ctrl.act == A_GAP && status.over_max)) begin
        mark_count_r <= '0;
      end else if (ctrl.act == A_STORE && slot_free) begin
        mark_count_r <= CW'(mark_count_r + 1'b1);
      end else begin
        mark_count_r <= mark_count_r;
      end
      priority if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end else begin
        out_valid_r <= out_valid_r;
      end
    end
  end

  // decode payload
  always_ff @(posedge clk) begin
    if (edge_take) begin
      width_r <= in_data.time_us - last_edge_r;
    end
    if (ctrl.act == A_INIT) begin
      code_r <= '0;
      bits_r <= '0;
      idx_r  <= '0;
    end
    if (ctrl.act == A_RD2) begin
      first_r <= rd_data_r;
    end
    if (ctrl.act == A_PAIR) begin
      // short then long gives 0, long then short gives 1
      if (first_r != rd_data_r) begin
        code_r <= {code_r[30:0], rd_data_r};
        if (bits_r != BITS_MAX) begin
          bits_r <= bits_r + 8'd1;
        end
      end
      idx_r <= CW'(idx_r + 2'd2);
    end
    if (emit_fire) begin
      out_word_r.address   <= code_r[31:6];
      out_word_r.unit      <= code_r[5:2];
      out_word_r.switch_on <= code_r[1];
      out_word_r.bit_count <= bits_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // a full buffer drops the mark
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.act == A_STORE && !slot_free) |=> mark_count_r == CW'(PULSE_SLOTS))
    else $error("mark stored past capacity");

  // the second read of a pair stays inside the stored marks
  a_pair_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.act == A_RD2) |-> (idx_plus2 < {1'b0, mark_count_r}))
    else $error("pair read beyond stored marks");

  // an edge restarts the width timer from its own timestamp
  a_edge_time: assert property (@(posedge clk) disable iff (!rst_n)
    edge_take |=> last_edge_r == $past(in_data.time_us))
    else $error("edge time not captured");

endmodule

[verif/ook_pulse_pair_decoder_core_tb.sv]
// Self-checking testbench for ook_pulse_pair_decoder_core: remote frames, noise and register
// settings in, decoded code words checked against a predictor kept in step here.
// Depends on opd_pkg and the core RTL only.
module ook_pulse_pair_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import opd_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 450;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // Indexes past the register list; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam int REG_SPARE_END = 2 ** CFG_IDX_W;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  ook_pulse_pair_decoder_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // Register copies
  logic [19:0] idle_gap_us    = MAX_GAP_RST;
  logic [19:0] frame_gap_us   = SYNC_GAP_RST;
  logic [8:0]  pulse_floor    = MIN_PULSES_RST;
  logic [15:0] short_below_us = SHORT_LIMIT_RST;
  logic [7:0]  bit_floor      = MIN_BITS_RST;

  // Line state as the decoder should see it
  logic        seen_level   = 1'b0;
  logic [31:0] seen_edge_us = '0;
  int          marks_held   = 0;
  bit          mark_short [PULSE_SLOTS_DEF];

  out_word_t codes_due [$];
  out_word_t due_code;
  int        mismatches  = 0;
  int        edges_sent  = 0;
  int        send_gap_pct  = 0;
  int        recv_stall_pct = 0;
  int unsigned cycle_count = 0;

  // Returns 1 when the sample completes a frame that yields a code word
  function automatic bit predict_sample(input in_word_t word, output out_word_t code_out);
    logic [31:0] width;
    logic [31:0] code;
    int          bits;
    code_out = '0;
    if (word.line_level == seen_level) return 1'b0;
    width        = word.time_us - seen_edge_us;
    seen_edge_us = word.time_us;
    seen_level   = word.line_level;
    if (width > idle_gap_us) begin
      marks_held = 0;
      return 1'b0;
    end
    if (marks_held < PULSE_SLOTS_DEF) begin
      mark_short[marks_held] = (width < short_below_us);
      marks_held++;
    end
    if (width <= frame_gap_us) return 1'b0;
    predict_sample = 1'b0;
    if (marks_held > pulse_floor) begin
      code = '0;
      bits = 0;
      // a pair is taken only when a further mark follows it, so the last mark is never paired
      for (int i = 0; i + 2 < marks_held; i += 2) begin
        if (mark_short[i] != mark_short[i + 1]) begin
          code = {code[30:0], mark_short[i + 1]};
          if (bits < BITS_MAX) bits++;
        end
      end
      if (bits >= bit_floor) begin
        code_out.address   = code[31:6];
        code_out.unit      = code[5:2];
        code_out.switch_on = code[1];
        code_out.bit_count = bits[7:0];
        predict_sample     = 1'b1;
      end
    end
    marks_held = 0;
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (codes_due.size() == 0) begin
        $display("%0t ns: code word with none due, expected nothing, got %h", $time, out_data);
        mismatches++;
      end else begin
        due_code = codes_due.pop_front();
        if (out_data.address !== due_code.address) begin
          $display("%0t ns: address expected %h got %h", $time, due_code.address,
                   out_data.address);
          mismatches++;
        end
        if (out_data.unit !== due_code.unit) begin
          $display("%0t ns: unit expected %h got %h", $time, due_code.unit, out_data.unit);
          mismatches++;
        end
        if (out_data.switch_on !== due_code.switch_on) begin
          $display("%0t ns: switch_on expected %b got %b", $time, due_code.switch_on,
                   out_data.switch_on);
          mismatches++;
        end
        if (out_data.bit_count !== due_code.bit_count) begin
          $display("%0t ns: bit_count expected %0d got %0d", $time, due_code.bit_count,
                   out_data.bit_count);
          mismatches++;
        end
      end
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_wdata = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      REG_MAX_GAP:     idle_gap_us    = value[19:0];
      REG_SYNC_GAP:    frame_gap_us   = value[19:0];
      REG_MIN_PULSES:  pulse_floor    = value[8:0];
      REG_SHORT_LIMIT: short_below_us = value[15:0];
      REG_MIN_BITS:    bit_floor      = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_sample(input in_word_t word);
    out_word_t code;
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (word.line_level != seen_level) edges_sent++;
    if (predict_sample(word, code)) codes_due.push_back(code);
  endtask

  // Drop valid so the accepted word is not taken twice
  task automatic hold_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Wait out any decode still running, even one that yields no word
  task automatic settle();
    wait (codes_due.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_gap_pct   = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic send_edge(input logic [31:0] width);
    in_word_t word;
    word.line_level = ~seen_level;
    word.time_us    = seen_edge_us + width;
    send_sample(word);
  endtask

  function automatic logic [31:0] short_width();
    if (short_below_us == 0) return 32'd0;
    return $urandom_range(int'(short_below_us) - 1, 0);
  endfunction

  function automatic logic [31:0] long_width();
    int lo;
    int hi;
    lo = int'(short_below_us);
    hi = int'(frame_gap_us);
    if (hi < lo) hi = lo;
    return $urandom_range(hi, lo);
  endfunction

  function automatic logic [31:0] sync_width();
    int lo;
    int hi;
    lo = int'(frame_gap_us) + 1;
    hi = int'(idle_gap_us);
    if (hi < lo) hi = lo;
    return $urandom_range(hi, lo);
  endfunction

  function automatic logic [31:0] idle_width();
    int unsigned lo;
    lo = int'(idle_gap_us) + 1;
    if ($urandom_range(1)) return $urandom_range(lo + 100000, lo);
    return $urandom_range(32'hFFFF_FFFF, lo);
  endfunction

  function automatic int pick_pairs();
    int need;
    need = (int'(pulse_floor) + 1) / 2;
    if (int'(bit_floor) > need) need = int'(bit_floor);
    case ($urandom_range(11))
      0:       return $urandom_range(136, 120);
      1:       return $urandom_range(need);
      default: return need + $urandom_range(6);
    endcase
  endfunction

  task automatic send_mark(input bit is_short);
    in_word_t stray;
    if ($urandom_range(19) == 0) begin
      stray.line_level = seen_level;
      stray.time_us    = $urandom;
      send_sample(stray);
    end
    send_edge(is_short ? short_width() : long_width());
  endtask

  // broken frames carry random pairs, same-width pairs among them
  task automatic send_frame(input int pairs, input bit broken);
    bit first_short;
    bit second_short;
    if ($urandom_range(2) == 0) send_edge(idle_width());
    for (int p = 0; p < pairs; p++) begin
      first_short  = bit'($urandom_range(1));
      second_short = broken ? bit'($urandom_range(1)) : !first_short;
      send_mark(first_short);
      send_mark(second_short);
    end
    if ($urandom_range(3) == 0) send_mark(bit'($urandom_range(1)));
    send_edge(sync_width());
  endtask

  task automatic send_noise(input int count);
    in_word_t word;
    repeat (count) begin
      word.line_level = 1'($urandom_range(1));
      word.time_us    = $urandom;
      send_sample(word);
    end
  endtask

  task automatic run_frames(input int edges);
    int stop_at;
    int pick;
    stop_at = edges_sent + edges;
    while (edges_sent < stop_at) begin
      pick = $urandom_range(9);
      if (pick == 0) send_noise($urandom_range(20, 6));
      else send_frame(pick_pairs(), pick == 1);
      if ($urandom_range(9) == 0) begin
        hold_input();
        wait (codes_due.size() == 0);
      end
    end
    hold_input();
  endtask

  task automatic test_level_and_wrap();
    settle();
    set_idling(0, 0);
    cfg_write(REG_MIN_PULSES, 20'd0);
    cfg_write(REG_MIN_BITS, 20'd1);
    send_sample(in_word_t'{1'b0, 32'h0000_0000});   // same level as after reset
    send_sample(in_word_t'{1'b1, 32'hFFFF_FE00});   // long idle: clear
    send_edge(32'd100);
    send_sample(in_word_t'{1'b0, 32'hFFFF_FFFF});   // same level again
    send_sample(in_word_t'{1'b1, 32'h0000_00F0});   // width spans the timestamp wrap
    send_edge(32'd700);
    send_edge(32'd100);
    send_edge(32'd100);
    send_edge(32'd100);
    send_edge(32'd700);
    send_edge(32'd700);
    send_edge(32'd8001);
    hold_input();
  endtask

  task automatic test_gap_boundaries();
    settle();
    send_edge(32'd20001);
    send_edge(32'd20000);   // kept as a mark, ends a frame with no bits
    send_edge(32'd600);     // at the short limit counts as long
    send_edge(32'd599);
    send_edge(32'd599);
    send_edge(32'd8000);    // at the sync gap is an ordinary mark
    send_edge(32'd8001);
    hold_input();
  endtask

  task automatic test_zero_bit_floor();
    settle();
    cfg_write(REG_MIN_BITS, 20'd0);
    send_edge(32'd30000);
    send_edge(32'd9000);
    hold_input();
  endtask

  task automatic test_reset_values();
    settle();
    set_idling(0, 0);
    cfg_write(REG_MAX_GAP, MAX_GAP_RST);
    cfg_write(REG_SYNC_GAP, SYNC_GAP_RST);
    cfg_write(REG_MIN_PULSES, MIN_PULSES_RST);
    cfg_write(REG_SHORT_LIMIT, SHORT_LIMIT_RST);
    cfg_write(REG_MIN_BITS, MIN_BITS_RST);
    run_frames(450);
  endtask

  task automatic test_fast_remote();
    settle();
    set_idling(65, 0);
    cfg_write(REG_MAX_GAP, 20'd5000);
    cfg_write(REG_SYNC_GAP, 20'd3000);
    cfg_write(REG_MIN_PULSES, 20'd20);
    cfg_write(REG_SHORT_LIMIT, 20'd300);
    cfg_write(REG_MIN_BITS, 20'd8);
    run_frames(200);
    wait (codes_due.size() == 0);
    run_frames(200);
  endtask

  task automatic test_every_edge_syncs();
    settle();
    set_idling(0, 65);
    cfg_write(REG_MAX_GAP, 20'hFFFFF);
    cfg_write(REG_SYNC_GAP, 20'd0);
    cfg_write(REG_MIN_PULSES, 20'd0);
    cfg_write(REG_SHORT_LIMIT, 20'h0FFFF);
    cfg_write(REG_MIN_BITS, 20'd0);
    run_frames(200);
  endtask

  task automatic test_never_decodes();
    settle();
    set_idling(29, 29);
    // max gap zero, the rest all-ones data; narrow registers keep their low bits
    cfg_write(REG_MAX_GAP, 20'd0);
    cfg_write(REG_SYNC_GAP, 20'hFFFFF);
    cfg_write(REG_MIN_PULSES, 20'hFFFFF);
    cfg_write(REG_SHORT_LIMIT, 20'hFFFFF);
    cfg_write(REG_MIN_BITS, 20'hFFFFF);
    repeat (100) begin
      if ($urandom_range(2) == 0) send_noise(1);
      else send_edge(32'd0);
    end
    hold_input();
  endtask

  task automatic test_random_settings();
    int gap;
    int lim;
    settle();
    set_idling(29, 29);
    for (int k = REG_SPARE_FIRST; k < REG_SPARE_END; k++)
      cfg_write(k[CFG_IDX_W-1:0], CFG_DATA_W'($urandom));
    for (int round = 0; round < 3; round++) begin
      settle();
      gap = $urandom_range(20'hFFFFF, 20000);
      lim = $urandom_range(2000, 100);
      cfg_write(REG_MAX_GAP, CFG_DATA_W'(gap));
      cfg_write(REG_SHORT_LIMIT, CFG_DATA_W'(lim));
      cfg_write(REG_SYNC_GAP, CFG_DATA_W'($urandom_range(gap - 1, 3 * lim + 1000)));
      cfg_write(REG_MIN_PULSES, CFG_DATA_W'($urandom_range(80)));
      cfg_write(REG_MIN_BITS, CFG_DATA_W'($urandom_range(40)));
      // overrun the mark buffer once
      if (round == 0) send_frame(136, 1'b0);
      run_frames(150);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_level_and_wrap();
    test_gap_boundaries();
    test_zero_bit_floor();
    test_reset_values();
    test_fast_remote();
    test_every_edge_syncs();
    test_never_decodes();
    test_random_settings();

    wait (codes_due.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
